// ===== rtl/bmp_rle8_encoder_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros shared by the encoder modules.
// Each macro expects clk and rst to be visible in the calling scope.
// ---------------------------------------------------------------------------
`ifndef BMP_RLE8_ENCODER_ASSERT_SVH
`define BMP_RLE8_ENCODER_ASSERT_SVH

// Same-cycle implication.
`define BRE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bmp_rle8_encoder: assertion failed");

// Next-cycle implication.
`define BRE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bmp_rle8_encoder: assertion failed");

`endif

// ===== rtl/bre_pkg.sv =====
// ---------------------------------------------------------------------------
// bre_pkg
// Types and constants shared by the RLE8 encoder front, queue and back end.
// ---------------------------------------------------------------------------
`default_nettype none

package bre_pkg;

  localparam int LENGTH_BITS = 24;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] RUN_MAX     = 8'd255;
  localparam logic [7:0] ESC_BYTE    = 8'd0;
  localparam logic [7:0] EOL_BYTE    = 8'd0;
  localparam logic [7:0] EOB_BYTE    = 8'd1;

  localparam logic [LENGTH_BITS-1:0] TOTAL_MAX = {LENGTH_BITS{1'b1}};
  // Shortest complete stream: one run pair, end of line, end of bitmap.
  localparam logic [LENGTH_BITS-1:0] MIN_STREAM_BYTES = LENGTH_BITS'(6);

  // One two-byte pair for the back end to emit.
  typedef struct packed {
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic       eob;   // pair is the end-of-bitmap marker
    logic       last;  // pair closes the work of its pixel
  } pair_job_t;

endpackage

`default_nettype wire

// ===== rtl/bre_front.sv =====
// ---------------------------------------------------------------------------
// bre_front
// Accepts pixels, tracks the open run and queues the pairs each pixel causes.
// ---------------------------------------------------------------------------
`default_nettype none

module bre_front
  import bre_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] pixel,
  input  wire logic       row_end,
  input  wire logic       image_end,
  output logic            push_valid,
  input  wire logic       push_ready,
  output pair_job_t       push_job
);

  // Bit positions of the pending job mask, in emit order.
  localparam int JOB_PREV  = 0;
  localparam int JOB_FLUSH = 1;
  localparam int JOB_EOL   = 2;
  localparam int JOB_EOB   = 3;

  logic [7:0] run_count;
  logic [7:0] run_colour;
  logic [3:0] pend;
  logic [7:0] prev_count;
  logic [7:0] prev_colour;
  logic [7:0] flush_count;
  logic [7:0] flush_colour;

  logic       accept;
  logic       push_done;
  logic [3:0] pend_rest;
  logic       run_full;
  logic       run_open;
  logic       run_match;
  logic       emit_prev;
  logic       frame_end;
  logic [7:0] count_next;
  logic [3:0] pend_next;

  always_comb begin
    pend_rest  = pend & (pend - 4'd1);
    push_valid = (pend != 4'd0);
    push_done  = push_valid && push_ready;
    in_ready   = (pend == 4'd0) || (push_done && (pend_rest == 4'd0));
    accept     = in_valid && in_ready;

    push_job             = '0;
    push_job.last        = (pend_rest == 4'd0);
    priority if (pend[JOB_PREV]) begin
      push_job.first_byte  = prev_count;
      push_job.second_byte = prev_colour;
    end else if (pend[JOB_FLUSH]) begin
      push_job.first_byte  = flush_count;
      push_job.second_byte = flush_colour;
    end else if (pend[JOB_EOL]) begin
      push_job.first_byte  = ESC_BYTE;
      push_job.second_byte = EOL_BYTE;
    end else begin
      push_job.first_byte  = ESC_BYTE;
      push_job.second_byte = EOB_BYTE;
      push_job.eob         = pend[JOB_EOB];
    end

    run_full   = (run_count == RUN_MAX);
    run_open   = (run_count != 8'd0);
    run_match  = (run_colour == pixel);
    emit_prev  = run_full || (run_open && !run_match);
    count_next = (run_open && !run_full && run_match) ? run_count + 8'd1 : 8'd1;
    frame_end  = row_end || image_end;

    pend_next            = '0;
    pend_next[JOB_PREV]  = emit_prev;
    pend_next[JOB_FLUSH] = frame_end;
    pend_next[JOB_EOL]   = frame_end;
    pend_next[JOB_EOB]   = image_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_count  <= '0;
      run_colour <= '0;
      pend       <= '0;
    end else if (accept) begin
      pend       <= pend_next;
      run_count  <= frame_end ? 8'd0 : count_next;
      run_colour <= image_end ? 8'd0 : pixel;
    end else if (push_done) begin
      pend <= pend_rest;
    end
  end

  // Hold the pair values of the accepted pixel until they are queued.
  always_ff @(posedge clk) begin
    if (accept) begin
      prev_count   <= run_count;
      prev_colour  <= run_colour;
      flush_count  <= count_next;
      flush_colour <= pixel;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bre_queue.sv =====
// ---------------------------------------------------------------------------
// bre_queue
// Short FIFO of pair jobs between the front and the back end.
// ---------------------------------------------------------------------------
`default_nettype none
`include "bmp_rle8_encoder_assert.svh"

module bre_queue
  import bre_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      push_valid,
  output logic           push_ready,
  input  wire pair_job_t push_job,
  output logic           head_valid,
  output pair_job_t      head_job,
  input  wire logic      pop
);

  pair_job_t         slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push_fire;
  logic              pop_fire;

  always_comb begin
    push_ready = (count != QCNT_W'(QUEUE_DEPTH));
    head_valid = (count != '0);
    head_job   = slots[rd_ptr];
    push_fire  = push_valid && push_ready;
    pop_fire   = pop && head_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (pop_fire) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (push_fire && !pop_fire) begin
        count <= count + QCNT_W'(1);
      end else if (pop_fire && !push_fire) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_fire) begin
      slots[wr_ptr] <= push_job;
    end
  end

  `BRE_ASSERT_NEXT(a_count_up, push_fire && !pop_fire, count == $past(count) + QCNT_W'(1))
  `BRE_ASSERT_NEXT(a_count_down, pop_fire && !push_fire, count == $past(count) - QCNT_W'(1))
  `BRE_ASSERT_IMP(a_ptr_gap, count == '0, wr_ptr == rd_ptr)

endmodule

`default_nettype wire

// ===== rtl/bre_back.sv =====
// ---------------------------------------------------------------------------
// bre_back
// Emits queued pairs one byte a cycle unless stalled; keeps saturating byte total.
// ---------------------------------------------------------------------------
`default_nettype none
`include "bmp_rle8_encoder_assert.svh"

module bre_back
  import bre_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   head_valid,
  input  wire pair_job_t              head_job,
  output logic                        pop,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [7:0]                  out_byte,
  output logic                        item_last,
  output logic                        stream_end,
  output logic [LENGTH_BITS-1:0]      total_length
);

  logic                   phase;      // 0: first byte of the pair, 1: second
  logic [LENGTH_BITS-1:0] byte_total;

  logic                   take;
  logic                   end_byte;
  logic [7:0]             byte_sel;
  logic [LENGTH_BITS-1:0] total_inc;

  always_comb begin
    take      = head_valid && (!out_valid || out_ready);
    end_byte  = phase && head_job.eob;
    byte_sel  = phase ? head_job.second_byte : head_job.first_byte;
    total_inc = (byte_total == TOTAL_MAX) ? byte_total : byte_total + LENGTH_BITS'(1);
    pop       = take && phase;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      phase      <= 1'b0;
      byte_total <= '0;
    end else if (take) begin
      out_valid  <= 1'b1;
      phase      <= !phase;
      // restart the count once the end-of-bitmap byte is out
      byte_total <= end_byte ? '0 : total_inc;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_byte     <= byte_sel;
      item_last    <= phase && head_job.last;
      stream_end   <= end_byte;
      total_length <= end_byte ? total_inc : '0;
    end
  end

  `BRE_ASSERT_IMP(a_end_is_last, out_valid && stream_end, item_last)
  `BRE_ASSERT_IMP(a_pair_held, phase, head_valid)
  `BRE_ASSERT_IMP(a_min_total, out_valid && stream_end, total_length >= MIN_STREAM_BYTES)

endmodule

`default_nettype wire

// ===== rtl/bmp_rle8_encoder.sv =====
// Path: a pixel's pairs pass the front's pending mask, a FIFO slot and the output register.
// Throughput: one output byte per cycle while pairs wait and m_axis_tready is high; a pixel
// closing a run adds a pair, one that only extends a run adds none. The back end's single
// byte port sets this. The front queues one pair per cycle while the FIFO has room and takes
// the next pixel with its last pair; a pixel's pairs (up to 4, 8 bytes) hold input till then.
// Reset: synchronous, clears run state, FIFO, byte total and output valid.
// ---------------------------------------------------------------------------
// bmp_rle8_encoder
// BMP RLE8 encoded-mode compressor with end-of-line and end-of-bitmap codes.
// ---------------------------------------------------------------------------
`default_nettype none

module bmp_rle8_encoder
  import bre_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] pixel
  input  wire logic        s_axis_tlast,   // row_end
  input  wire logic        s_axis_tuser,   // [0] image_end
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // [7:0] out_byte, [31:8] total_length
  output logic             m_axis_tlast,   // item_last
  output logic             m_axis_tuser    // [0] stream_end
);

  logic                   push_valid;
  logic                   push_ready;
  pair_job_t              push_job;
  logic                   head_valid;
  pair_job_t              head_job;
  logic                   pop;
  logic [7:0]             out_byte;
  logic [LENGTH_BITS-1:0] total_length;

  bre_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .pixel      (s_axis_tdata),
    .row_end    (s_axis_tlast),
    .image_end  (s_axis_tuser),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  bre_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  bre_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_job     (head_job),
    .pop          (pop),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_byte     (out_byte),
    .item_last    (m_axis_tlast),
    .stream_end   (m_axis_tuser),
    .total_length (total_length)
  );

  assign m_axis_tdata = {total_length, out_byte};

endmodule

`default_nettype wire
